// ===== hw/rtl/ifs_pkg.sv =====
// ----------------------------------------------------------------------------
// ifs_pkg: shared types and constants
// Request and result word layouts, field codes and fixed-point constants.
// ----------------------------------------------------------------------------
package ifs_pkg;

	typedef struct packed {
		logic              req_type;
		logic [2:0]        map_index;
		logic [2:0]        coeff_select;
		logic signed [23:0] coeff_value;
		logic [6:0]        random_pct;
	} ifs_req_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [2:0]         chosen_map;
		logic [3:0]         pixel_color;
		logic signed [15:0] plot_x;
		logic signed [15:0] plot_y;
		logic               on_screen;
	} ifs_res_t;

	// queued step: the chosen map only
	typedef struct packed {
		logic [2:0] map;
	} ifs_job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SUM,
		BK_PIX,
		BK_OUT
	} ifs_bk_state_t;

	localparam logic       REQ_WRITE  = 1'b0;
	localparam logic       REQ_STEP   = 1'b1;
	localparam logic [2:0] SEL_WEIGHT = 3'd6;
	localparam logic [2:0] SEL_COLOR  = 3'd7;

	localparam logic [3:0] REG_MAP_COUNT = 4'd0;
	localparam logic [3:0] REG_SCALE_X   = 4'd1;
	localparam logic [3:0] REG_SCALE_Y   = 4'd2;
	localparam logic [3:0] REG_OFFSET_X  = 4'd3;
	localparam logic [3:0] REG_OFFSET_Y  = 4'd4;
	localparam logic [3:0] REG_SWAP_AXES = 4'd5;

	localparam logic signed [31:0] POS_ONE = 32'sh0001_0000;

endpackage

// ===== hw/rtl/ifs_chaos_game_point_generator.sv =====
// ----------------------------------------------------------------------------
// ifs_chaos_game_point_generator: chaos-game IFS point generator
// Table writes and point steps in, one plotted point out per step.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  request  | start / busy       | req (ifs_req_t)
//  result   | done (1 cycle)     | res (ifs_res_t)
//  config   | cfg_we             | cfg_index, cfg_data
//
// A step runs the selection scan up to the chosen map, then the queue, then
// the affine datapath states BK_MUL, BK_SUM, BK_PIX and BK_OUT, and then the
// registered result is shown. busy holds the input until the datapath is idle,
// so the next word is taken at the earliest in the cycle the result is shown.
// Reset restores the registers and the point to 1.0; tables are undefined.
// The result is shown for one cycle and cannot be stalled.
module ifs_chaos_game_point_generator import ifs_pkg::*; #(
	parameter int SCREEN_W = 320,
	parameter int SCREEN_H = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  ifs_req_t    req,
	output logic        done,
	output ifs_res_t    res,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	logic [3:0]       map_count_q;
	logic signed [9:0] scale_x_q, scale_y_q, offset_x_q, offset_y_q;
	logic             swap_q;
	logic             take, scan_busy, push, pop, q_full, q_empty, bk_busy;
	ifs_job_t         job_in, job_out;

	// one job in flight at a time keeps the point chain in order
	assign busy = scan_busy || push || !q_empty || bk_busy;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_count_q <= 4'd4;
			scale_x_q   <= 10'sd29;
			scale_y_q   <= -10'sd29;
			offset_x_q  <= 10'sd160;
			offset_y_q  <= 10'sd100;
			swap_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_COUNT: map_count_q <= cfg_data[3:0];
				REG_SCALE_X:   scale_x_q   <= cfg_data;
				REG_SCALE_Y:   scale_y_q   <= cfg_data;
				REG_OFFSET_X:  offset_x_q  <= cfg_data;
				REG_OFFSET_Y:  offset_y_q  <= cfg_data;
				REG_SWAP_AXES: swap_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ifs_front u_front (
		.clk, .arst_n, .take, .req,
		.map_count(map_count_q), .q_full,
		.scan_busy, .push, .job(job_in)
	);

	ifs_queue u_queue (
		.clk, .arst_n, .push, .din(job_in), .pop,
		.full(q_full), .empty(q_empty), .dout(job_out)
	);

	ifs_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
		.clk, .arst_n, .take, .req,
		.scale_x(scale_x_q), .scale_y(scale_y_q),
		.offset_x(offset_x_q), .offset_y(offset_y_q), .swap_axes(swap_q),
		.q_empty, .job(job_out), .pop, .busy_out(bk_busy),
		.res_valid(done), .res
	);
endmodule

// ===== hw/rtl/ifs_front.sv =====
// ----------------------------------------------------------------------------
// ifs_front: request intake and map selection
// Takes table writes into the weight table and selects a map for each step
// by a scan over the cumulative weights, one map a cycle unless q_full.
// ----------------------------------------------------------------------------
module ifs_front import ifs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  ifs_req_t        req,
	input  logic [3:0]      map_count,
	input  logic            q_full,
	output logic            scan_busy,
	output logic            push,
	output ifs_job_t        job
);
	logic [6:0] weight_q [8];
	logic       scan_q;
	logic [2:0] idx_q;
	logic [9:0] cum_q;
	logic [6:0] r_q;
	logic [2:0] last;
	logic [9:0] cum_nx;
	logic       hit;
	logic       done;

	always_comb begin
		if (map_count == 4'd0)
			last = 3'd0;
		else if (map_count > 4'd8)
			last = 3'd7;
		else
			last = 3'(map_count - 4'd1);
		cum_nx = cum_q + {3'd0, weight_q[idx_q]};
		hit    = {3'd0, r_q} <= cum_nx;
		done   = hit || (idx_q == last);
	end

	assign scan_busy = scan_q;
	assign push      = scan_q && !q_full && done;
	assign job.map   = hit ? idx_q : last;

	always_ff @(posedge clk) begin
		if (take && req.req_type == REQ_WRITE && req.coeff_select == SEL_WEIGHT) begin
			if (req.coeff_value < 0)
				weight_q[req.map_index] <= 7'd0;
			else if (req.coeff_value > 24'sd100)
				weight_q[req.map_index] <= 7'd100;
			else
				weight_q[req.map_index] <= req.coeff_value[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= 1'b0;
			idx_q  <= '0;
			cum_q  <= '0;
			r_q    <= '0;
		end else if (take && req.req_type == REQ_STEP) begin
			scan_q <= 1'b1;
			idx_q  <= '0;
			cum_q  <= '0;
			r_q    <= req.random_pct;
		end else if (scan_q && !q_full) begin
			if (done) begin
				scan_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
				cum_q <= cum_nx;
			end
		end
	end
endmodule

// ===== hw/rtl/ifs_queue.sv =====
// ----------------------------------------------------------------------------
// ifs_queue: two-entry job queue
// Decouples map selection from the affine datapath.
// ----------------------------------------------------------------------------
module ifs_queue import ifs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ifs_job_t din,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output ifs_job_t dout
);
	ifs_job_t   mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== hw/rtl/ifs_back.sv =====
// ----------------------------------------------------------------------------
// ifs_back: affine map and pixel datapath
// Holds the coefficient and color tables and the point; applies one map
// per job in BK_MUL, BK_SUM, BK_PIX and BK_OUT and drives the result word.
// ----------------------------------------------------------------------------
module ifs_back import ifs_pkg::*; #(
	parameter int SCREEN_W = 320,
	parameter int SCREEN_H = 200
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  ifs_req_t        req,
	input  logic signed [9:0] scale_x,
	input  logic signed [9:0] scale_y,
	input  logic signed [9:0] offset_x,
	input  logic signed [9:0] offset_y,
	input  logic            swap_axes,
	input  logic            q_empty,
	input  ifs_job_t        job,
	output logic            pop,
	output logic            busy_out,
	output logic            res_valid,
	output ifs_res_t        res
);
	// one entry per map, holding coefficients a..f side by side
	logic [5:0][23:0]   coeff_q [8];
	logic [3:0]         color_q [8];
	logic signed [31:0] pos_x_q, pos_y_q;
	ifs_bk_state_t      st_q, st_nx;
	logic [2:0]         map_q;
	logic signed [23:0] ca_q, cb_q, cc_q, cd_q, ce_q, cf_q;
	logic signed [55:0] pa_q, pb_q, pc_q, pd_q;
	logic signed [41:0] qx_q, qy_q;
	logic [3:0]         col_q;
	logic               rv_q;
	ifs_res_t           res_q;

	logic signed [57:0] sx, sy;
	logic signed [41:0] rx, ry, u, v;
	logic signed [31:0] nx, ny;
	logic signed [42:0] tx, ty;
	logic signed [26:0] fx, fy;
	logic signed [15:0] px, py;

	// coefficient and color writes land in the table memory
	always_ff @(posedge clk) begin
		if (take && req.req_type == REQ_WRITE) begin
			if (req.coeff_select < SEL_WEIGHT)
				coeff_q[req.map_index][req.coeff_select] <= req.coeff_value;
			else if (req.coeff_select == SEL_COLOR)
				color_q[req.map_index] <= req.coeff_value[3:0];
		end
	end

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			BK_IDLE: if (!q_empty) st_nx = BK_MUL;
			BK_MUL:  st_nx = BK_SUM;
			BK_SUM:  st_nx = BK_PIX;
			BK_PIX:  st_nx = BK_OUT;
			BK_OUT:  st_nx = BK_IDLE;
			default: st_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = (st_q == BK_IDLE) && !q_empty;
		busy_out = st_q != BK_IDLE;
	end

	always_comb begin
		// round to Q16.16 and saturate
		sx = 58'(pa_q) + 58'(pb_q) + (58'(ce_q) <<< 16) + 58'sd32768;
		sy = 58'(pc_q) + 58'(pd_q) + (58'(cf_q) <<< 16) + 58'sd32768;
		rx = 42'(sx >>> 16);
		ry = 42'(sy >>> 16);
		nx = (rx > 42'sd2147483647) ? 32'sh7fffffff :
			(rx < -42'sd2147483648) ? 32'sh80000000 : rx[31:0];
		ny = (ry > 42'sd2147483647) ? 32'sh7fffffff :
			(ry < -42'sd2147483648) ? 32'sh80000000 : ry[31:0];
		// truncate toward zero, then saturate to 16 bits
		tx = (qx_q < 0) ? 43'(qx_q) + 43'sd65535 : 43'(qx_q);
		ty = (qy_q < 0) ? 43'(qy_q) + 43'sd65535 : 43'(qy_q);
		fx = 27'(tx >>> 16);
		fy = 27'(ty >>> 16);
		px = (fx > 27'sd32767) ? 16'sh7fff : (fx < -27'sd32768) ? 16'sh8000 : fx[15:0];
		py = (fy > 27'sd32767) ? 16'sh7fff : (fy < -27'sd32768) ? 16'sh8000 : fy[15:0];
		u  = 42'(swap_axes ? pos_y_q : pos_x_q);
		v  = 42'(swap_axes ? pos_x_q : pos_y_q);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			map_q <= job.map;
			ca_q  <= coeff_q[job.map][0];
			cb_q  <= coeff_q[job.map][1];
			cc_q  <= coeff_q[job.map][2];
			cd_q  <= coeff_q[job.map][3];
			ce_q  <= coeff_q[job.map][4];
			cf_q  <= coeff_q[job.map][5];
			col_q <= color_q[job.map];
		end
		if (st_q == BK_MUL) begin
			pa_q <= 56'(ca_q) * 56'(pos_x_q);
			pb_q <= 56'(cb_q) * 56'(pos_y_q);
			pc_q <= 56'(cc_q) * 56'(pos_x_q);
			pd_q <= 56'(cd_q) * 56'(pos_y_q);
		end
		if (st_q == BK_PIX) begin
			qx_q <= u * 42'(scale_x) + (42'(offset_x) <<< 16);
			qy_q <= v * 42'(scale_y) + (42'(offset_y) <<< 16);
		end
		if (st_q == BK_OUT) begin
			res_q.point_x     <= pos_x_q;
			res_q.point_y     <= pos_y_q;
			res_q.chosen_map  <= map_q;
			res_q.pixel_color <= col_q;
			res_q.plot_x      <= px;
			res_q.plot_y      <= py;
			res_q.on_screen   <= px >= 0 && 32'(px) < SCREEN_W && py >= 0 &&
				32'(py) < SCREEN_H;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= BK_IDLE;
			rv_q    <= 1'b0;
			pos_x_q <= POS_ONE;
			pos_y_q <= POS_ONE;
		end else begin
			st_q <= st_nx;
			rv_q <= st_q == BK_OUT;
			if (st_q == BK_SUM) begin
				pos_x_q <= nx;
				pos_y_q <= ny;
			end
		end
	end

	assign res_valid = rv_q;
	assign res       = res_q;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for ifs_chaos_game_point_generator
// Loads the map tables, steps the point under several register settings and
// sender idle rates, and checks every plotted point against a local predictor
// of the selection scan, the affine map and the pixel transform.
// ----------------------------------------------------------------------------
module tb;
	import ifs_pkg::*;

	localparam int SCREEN_W   = 320;
	localparam int SCREEN_H   = 200;
	localparam int N_MAPS     = 8;
	localparam int SETTLE     = 48;
	localparam int STALL_MAX  = 2000;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	ifs_req_t   req;
	logic       done;
	ifs_res_t   res;
	logic       cfg_we;
	logic [3:0] cfg_index;
	logic [9:0] cfg_data;

	ifs_chaos_game_point_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [3:0]         mdl_map_count;
	logic signed [9:0]  mdl_scale_x, mdl_scale_y, mdl_offset_x, mdl_offset_y;
	logic               mdl_swap;
	logic signed [31:0] mdl_pos_x, mdl_pos_y;
	logic signed [23:0] mdl_coeff [N_MAPS*6];
	int unsigned        mdl_weight [N_MAPS];
	logic [3:0]         mdl_color [N_MAPS];

	ifs_res_t pending_points[$];
	int       n_errors;
	int       idle_pct;
	int       stall_cnt;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, exp);
		n_errors++;
	endtask

	function automatic longint sat_range(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint to_plot(input logic signed [31:0] p, input logic signed [9:0] scale,
			input logic signed [9:0] offset);
		longint t;
		t = longint'(p) * longint'(scale) + longint'(offset) * 65536;
		return sat_range(t / 65536, -32768, 32767);
	endfunction

	// advance the point by one step and return the plotted point
	function automatic ifs_res_t step_point(input logic [6:0] pct);
		ifs_res_t    r;
		int unsigned n, k, cum;
		longint      sx, sy, px, py;
		logic signed [31:0] u, v;
		n = mdl_map_count;
		if (n < 1) n = 1;
		if (n > N_MAPS) n = N_MAPS;
		k = n - 1;
		cum = 0;
		for (int i = 0; i < n; i++) begin
			cum += mdl_weight[i];
			if (pct <= cum) begin
				k = i;
				break;
			end
		end
		sx = longint'(mdl_coeff[k*6]) * mdl_pos_x + longint'(mdl_coeff[k*6+1]) * mdl_pos_y
			+ longint'(mdl_coeff[k*6+4]) * 65536;
		sy = longint'(mdl_coeff[k*6+2]) * mdl_pos_x + longint'(mdl_coeff[k*6+3]) * mdl_pos_y
			+ longint'(mdl_coeff[k*6+5]) * 65536;
		mdl_pos_x = 32'(sat_range((sx + 32768) >>> 16, -64'sd2147483648, 64'sd2147483647));
		mdl_pos_y = 32'(sat_range((sy + 32768) >>> 16, -64'sd2147483648, 64'sd2147483647));
		u = mdl_swap ? mdl_pos_y : mdl_pos_x;
		v = mdl_swap ? mdl_pos_x : mdl_pos_y;
		px = to_plot(u, mdl_scale_x, mdl_offset_x);
		py = to_plot(v, mdl_scale_y, mdl_offset_y);
		r.point_x     = mdl_pos_x;
		r.point_y     = mdl_pos_y;
		r.chosen_map  = 3'(k);
		r.pixel_color = mdl_color[k];
		r.plot_x      = 16'(px);
		r.plot_y      = 16'(py);
		r.on_screen   = px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H;
		return r;
	endfunction

	task automatic apply_word(input ifs_req_t w);
		longint val;
		val = w.coeff_value;
		if (w.req_type == REQ_STEP) begin
			pending_points.push_back(step_point(w.random_pct));
		end else if (w.coeff_select == SEL_WEIGHT) begin
			mdl_weight[w.map_index] = int'(sat_range(val, 0, 100));
		end else if (w.coeff_select == SEL_COLOR) begin
			mdl_color[w.map_index] = w.coeff_value[3:0];
		end else begin
			mdl_coeff[w.map_index*6 + w.coeff_select] = w.coeff_value;
		end
	endtask

	// hold start high between back-to-back words; drop it only for a gap
	task automatic send_word(input ifs_req_t w);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= w;
		do @(posedge clk); while (busy);
		apply_word(w);
	endtask

	task automatic stop_sending();
		start <= 1'b0;
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [9:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAP_COUNT: mdl_map_count = data[3:0];
			REG_SCALE_X:   mdl_scale_x   = data;
			REG_SCALE_Y:   mdl_scale_y   = data;
			REG_OFFSET_X:  mdl_offset_x  = data;
			REG_OFFSET_Y:  mdl_offset_y  = data;
			REG_SWAP_AXES: mdl_swap      = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		stop_sending();
		while (pending_points.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic ifs_req_t table_word(input logic [2:0] m, input logic [2:0] sel,
			input logic signed [23:0] val);
		ifs_req_t w;
		w = ifs_req_t'({$urandom, $urandom});
		w.req_type     = REQ_WRITE;
		w.map_index    = m;
		w.coeff_select = sel;
		w.coeff_value  = val;
		return w;
	endfunction

	function automatic ifs_req_t step_word(input logic [6:0] pct);
		ifs_req_t w;
		w = ifs_req_t'({$urandom, $urandom});
		w.req_type   = REQ_STEP;
		w.random_pct = pct;
		return w;
	endfunction

	function automatic logic signed [23:0] rand_coeff();
		if ($urandom_range(99) < 85)
			return 24'($signed($urandom_range(0, 131072)) - 65536);
		return 24'($urandom);
	endfunction

	function automatic ifs_req_t rand_word();
		logic [2:0] sel;
		logic signed [23:0] val;
		if ($urandom_range(99) < 75)
			return step_word($urandom_range(99) < 85 ? 7'($urandom_range(99)) : 7'($urandom));
		sel = 3'($urandom);
		if (sel == SEL_WEIGHT)
			val = $urandom_range(99) < 85 ? 24'($urandom_range(100)) : 24'($urandom);
		else if (sel == SEL_COLOR)
			val = 24'($urandom);
		else
			val = rand_coeff();
		return table_word(3'($urandom), sel, val);
	endfunction

	function automatic logic [9:0] rand_reg();
		return 10'($urandom);
	endfunction

	// fill every table entry so that no step reads an unwritten one
	task automatic test_load_tables();
		for (int m = 0; m < N_MAPS; m++) begin
			for (int s = 0; s < 6; s++) send_word(table_word(3'(m), 3'(s), rand_coeff()));
			send_word(table_word(3'(m), SEL_WEIGHT, 24'($urandom_range(5, 30))));
			send_word(table_word(3'(m), SEL_COLOR, 24'($urandom)));
		end
	endtask

	task automatic test_directed();
		send_word(step_word(7'd0));
		send_word(step_word(7'd99));
		send_word(step_word(7'd127));
		// out-of-range weights saturate
		send_word(table_word(3'd0, SEL_WEIGHT, -24'sd5));
		send_word(table_word(3'd1, SEL_WEIGHT, 24'sd200));
		send_word(step_word(7'd0));
		send_word(step_word(7'd100));
		send_word(table_word(3'd7, SEL_COLOR, 24'h7FFFF3));
		// extreme coefficients drive the point into saturation
		send_word(table_word(3'd0, 3'd0, 24'h7FFFFF));
		send_word(table_word(3'd0, 3'd3, 24'h800000));
		send_word(table_word(3'd0, 3'd4, 24'h7FFFFF));
		send_word(table_word(3'd0, 3'd5, 24'h800000));
		send_word(step_word(7'd0));
		send_word(step_word(7'd0));
		send_word(table_word(3'd0, SEL_WEIGHT, 24'sd0));
		send_word(step_word(7'd0));
		send_word(step_word(7'd127));
		wait_idle();
		write_reg(REG_MAP_COUNT, 10'd0);
		write_reg(REG_SCALE_X, 10'h200);
		write_reg(REG_SCALE_Y, 10'h1FF);
		write_reg(REG_OFFSET_X, 10'h1FF);
		write_reg(REG_OFFSET_Y, 10'h200);
		write_reg(REG_SWAP_AXES, 10'd1);
		write_reg(4'd9, 10'h3FF);
		send_word(step_word(7'd50));
		send_word(step_word(7'd0));
		wait_idle();
		write_reg(REG_MAP_COUNT, 10'd15);
		send_word(step_word(7'd127));
		send_word(step_word(7'd1));
		wait_idle();
	endtask

	task automatic test_random_phase(input int pct, input int n_items);
		idle_pct = pct;
		write_reg(REG_MAP_COUNT, 10'($urandom_range(1, 8)));
		write_reg(REG_SCALE_X, $urandom_range(1) ? 10'($urandom_range(10, 40)) : rand_reg());
		write_reg(REG_SCALE_Y, $urandom_range(1) ? 10'(-$urandom_range(10, 40)) : rand_reg());
		write_reg(REG_OFFSET_X, $urandom_range(1) ? 10'd160 : rand_reg());
		write_reg(REG_OFFSET_Y, $urandom_range(1) ? 10'd100 : rand_reg());
		write_reg(REG_SWAP_AXES, 10'($urandom));
		for (int i = 0; i < n_items; i++) begin
			// stretches with no idling inside idle phases
			if (i % 60 == 30) idle_pct = 0;
			if (i % 60 == 45) idle_pct = pct;
			send_word(rand_word());
		end
		wait_idle();
	endtask

	// compare each plotted point with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				ifs_res_t e;
				e = pending_points.pop_front();
				if (res.point_x !== e.point_x) report_mismatch("point_x", res.point_x, e.point_x);
				if (res.point_y !== e.point_y) report_mismatch("point_y", res.point_y, e.point_y);
				if (res.chosen_map !== e.chosen_map)
					report_mismatch("chosen_map", res.chosen_map, e.chosen_map);
				if (res.pixel_color !== e.pixel_color)
					report_mismatch("pixel_color", res.pixel_color, e.pixel_color);
				if (res.plot_x !== e.plot_x) report_mismatch("plot_x", res.plot_x, e.plot_x);
				if (res.plot_y !== e.plot_y) report_mismatch("plot_y", res.plot_y, e.plot_y);
				if (res.on_screen !== e.on_screen)
					report_mismatch("on_screen", res.on_screen, e.on_screen);
			end
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_MAX) begin
			$display("[ifs_chaos_game_point_generator] ERROR");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		stall_cnt = 0;
		n_errors  = 0;
		idle_pct  = 0;
		mdl_map_count = 4'd4;
		mdl_scale_x   = 10'sd29;
		mdl_scale_y   = -10'sd29;
		mdl_offset_x  = 10'sd160;
		mdl_offset_y  = 10'sd100;
		mdl_swap      = 1'b0;
		mdl_pos_x     = POS_ONE;
		mdl_pos_y     = POS_ONE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_tables();
		test_directed();
		test_random_phase(0, 230);
		test_random_phase(88, 200);
		test_random_phase(0, 230);
		test_random_phase(6, 230);
		if (n_errors == 0 && pending_points.size() == 0) begin
			$display("[ifs_chaos_game_point_generator] OK");
		end else begin
			if (pending_points.size() != 0) report_mismatch("words left over", pending_points.size(), 0);
			$display("[ifs_chaos_game_point_generator] ERROR");
		end
		$finish;
	end

endmodule

// ===== ifs_chaos_game_point_generator.f =====
hw/rtl/ifs_pkg.sv
hw/rtl/ifs_front.sv
hw/rtl/ifs_queue.sv
hw/rtl/ifs_back.sv
hw/rtl/ifs_chaos_game_point_generator.sv
tb/tb.sv
